// ===== src/ptal_pkg.sv =====
// Shared types and constants for the paper-tape absolute loader.
`timescale 1ns / 1ps

package ptal_pkg;

  // Header bytes counted in the block length: sync pair, count, address.
  localparam logic [15:0] HEADER_BYTES = 16'd6;
  // Load address that ends the tape.
  localparam logic [15:0] END_ADDRESS  = 16'd1;
  localparam logic [7:0]  SYNC_FIRST   = 8'd1;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_SYNC2  = 4'd1,
    PH_CNT_LO = 4'd2,
    PH_CNT_HI = 4'd3,
    PH_ADR_LO = 4'd4,
    PH_ADR_HI = 4'd5,
    PH_DATA   = 4'd6,
    PH_CKSUM  = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] addr;
    logic [7:0]  value;
  } result_t;

endpackage

// ===== src/ptal_if.sv =====
// Valid/ready channel interfaces for tape words and loader results.
`timescale 1ns / 1ps

interface ptal_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] tape_byte;

  modport source (output valid, output req_type, output tape_byte, input ready);
  modport sink   (input valid, input req_type, input tape_byte, output ready);
endinterface

interface ptal_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] byte_address;
  logic [7:0]  byte_value;

  modport source (output valid, output result_kind, output byte_address,
                  output byte_value, input ready);
  modport sink   (input valid, input result_kind, input byte_address,
                  input byte_value, output ready);
endinterface

// ===== src/ptal_parser.sv =====
// Block parser: phase register, running sum, count and address registers.
`timescale 1ns / 1ps

module ptal_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              req_type,
  input  logic [7:0]        tape_byte,
  output logic              res_valid,
  output ptal_pkg::result_t res
);
  import ptal_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] addr_r, addr_nxt;

  logic [7:0]  sum_add;
  logic [15:0] word;
  logic [15:0] left_hdr;
  logic [15:0] left_dec;

  assign sum_add  = sum_r + tape_byte;
  assign word     = {tape_byte, low_r};
  assign left_hdr = left_r - HEADER_BYTES;
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    low_nxt   = low_r;
    left_nxt  = left_r;
    addr_nxt  = addr_r;
    res_valid = 1'b0;
    res.kind  = KIND_WRITE;
    res.addr  = 16'd0;
    res.value = 8'd0;
    if (req_type) begin
      // End of tape: fine between blocks, an error inside one.
      unique case (phase_r) inside
        PH_HUNT, PH_SYNC2: begin
          res_valid = 1'b1;
          res.kind  = KIND_OK;
          phase_nxt = PH_DONE;
        end
        PH_CNT_LO, PH_CNT_HI, PH_ADR_LO, PH_ADR_HI, PH_DATA, PH_CKSUM: begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          phase_nxt = PH_DONE;
        end
        default: ;
      endcase
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (tape_byte == SYNC_FIRST) begin
            sum_nxt   = SYNC_FIRST;
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          sum_nxt   = sum_add;
          phase_nxt = (tape_byte == 8'd0) ? PH_CNT_LO : PH_HUNT;
        end
        PH_CNT_LO: begin
          sum_nxt   = sum_add;
          low_nxt   = tape_byte;
          phase_nxt = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          sum_nxt   = sum_add;
          left_nxt  = word;
          phase_nxt = PH_ADR_LO;
        end
        PH_ADR_LO: begin
          sum_nxt   = sum_add;
          low_nxt   = tape_byte;
          phase_nxt = PH_ADR_HI;
        end
        PH_ADR_HI: begin
          sum_nxt = sum_add;
          if (word == END_ADDRESS) begin
            res_valid = 1'b1;
            res.kind  = KIND_OK;
            phase_nxt = PH_DONE;
          end else if (left_r == 16'd0) begin
            phase_nxt = PH_HUNT;
          end else begin
            addr_nxt  = word;
            left_nxt  = left_hdr;
            phase_nxt = (left_hdr == 16'd0) ? PH_CKSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          sum_nxt   = sum_add;
          addr_nxt  = addr_r + 16'd1;
          left_nxt  = left_dec;
          res_valid = 1'b1;
          res.addr  = addr_r;
          res.value = tape_byte;
          if (left_dec == 16'd0) begin
            phase_nxt = PH_CKSUM;
          end
        end
        PH_CKSUM: begin
          sum_nxt = sum_add;
          if (sum_add != 8'd0) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= 8'd0;
      low_r   <= 8'd0;
      left_r  <= 16'd0;
      addr_r  <= 16'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      low_r   <= low_nxt;
      left_r  <= left_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

// ===== src/ptal_out_reg.sv =====
// Result register: holds one result word until the sink takes it.
`timescale 1ns / 1ps

module ptal_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              res_valid,
  input  ptal_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output ptal_pkg::result_t out_res,
  output logic              can_load
);
  import ptal_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/paper_tape_absolute_loader_core.sv =====
// Top level of the paper-tape absolute loader: tape words in, byte writes out.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-------------
//   in_ch    | in  | req_type, tape_byte                       | valid/ready
//   out_ch   | out | result_kind, byte_address, byte_value     | valid/ready
//
// One tape word is taken per cycle; its result (if any) shows on out_ch the
// next cycle from the result register. The parser updates its state in the
// same cycle it takes the word, so the phase/sum/count path sets the clock.
// Reset (rst_n low at a clock edge) returns the parser to hunting for sync.
// A stalled result holds in_ch.ready low; a word is taken again in the cycle
// the pending result leaves, so back-to-back flow continues with no bubble.
`timescale 1ns / 1ps

module paper_tape_absolute_loader_core (
  input  logic       clk,
  input  logic       rst_n,
  ptal_in_if.sink    in_ch,
  ptal_out_if.source out_ch
);
  import ptal_pkg::*;

  logic    accept;
  logic    can_load;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Take a word whenever the result register is empty or draining.
  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  // Parse the word and compute its result in one pass.
  ptal_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_ch.req_type),
    .tape_byte (in_ch.tape_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result until the sink takes it.
  ptal_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .can_load  (can_load)
  );

  assign out_ch.result_kind  = out_res.kind;
  assign out_ch.byte_address = out_res.addr;
  assign out_ch.byte_value   = out_res.value;

endmodule

// ===== src/ptal_checker.sv =====
// Port-level assertions for the loader core, bound to the top level.
`timescale 1ns / 1ps

module ptal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [15:0] byte_address,
  input logic [7:0]  byte_value
);
  import ptal_pkg::*;

  logic done_r;

  // Remember that a final word (ok or error) has been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (out_valid && out_ready && result_kind != KIND_WRITE) begin
      done_r <= 1'b1;
    end
  end

  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !out_valid)
    else $error("result word after the load ended");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_end_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && result_kind != KIND_WRITE) |->
      (byte_address == 16'd0 && byte_value == 8'd0))
    else $error("final word carries a payload");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_kind) && $stable(byte_address) &&
       $stable(byte_value)))
    else $error("stalled result word changed");

  a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |-> out_valid)
    else $error("input stalled without a pending result");

endmodule

bind paper_tape_absolute_loader_core ptal_checker u_ptal_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_kind  (out_ch.result_kind),
  .byte_address (out_ch.byte_address),
  .byte_value   (out_ch.byte_value)
);

// ===== bench/tb.sv =====
// Testbench for the paper-tape absolute loader core: tape words in, byte writes checked out.
`timescale 1ns / 1ps

module tb;
  import ptal_pkg::*;

  typedef struct packed {
    bit         req;
    logic [7:0] tbyte;
    bit         pinned;
    result_t    pin;
  } tape_word_t;

  typedef struct packed {
    bit       req;
    bit [7:0] tbyte;
    bit       pinned;
    bit [15:0] paddr;
    bit [7:0] pval;
  } tape_row_t;

  // Directed rows: {end flag, byte, pinned, write address, write value}.
  tape_row_t tape_rows [27] = '{
    {1'b0, 8'h01, 1'b0, 16'h0000, 8'h00},  // sync
    {1'b0, 8'hFF, 1'b0, 16'h0000, 8'h00},  // bad second sync, all ones
    {1'b0, 8'h01, 1'b0, 16'h0000, 8'h00},  // sync
    {1'b0, 8'h01, 1'b0, 16'h0000, 8'h00},  // bad second sync, not a new sync
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},  // still hunting, ignored
    // zero count: back to hunting after the address
    {1'b0, 8'h01, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h34, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h12, 1'b0, 16'h0000, 8'h00},
    // two data bytes at the top address, write address wraps to zero
    {1'b0, 8'h01, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h08, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'hFF, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'hFF, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'hAA, 1'b1, 16'hFFFF, 8'hAA},
    {1'b0, 8'h55, 1'b1, 16'h0000, 8'h55},
    {1'b0, 8'hFA, 1'b0, 16'h0000, 8'h00},
    // count of six: no data, checksum straight after the address
    {1'b0, 8'h01, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h06, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'h00, 1'b0, 16'h0000, 8'h00},
    {1'b0, 8'hF9, 1'b0, 16'h0000, 8'h00}
  };

  logic clk;
  logic rst_n;

  ptal_in_if  in_ch ();
  ptal_out_if out_ch ();

  paper_tape_absolute_loader_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tape_word_t  tape_words [$];
  result_t     due_results [$];
  tape_word_t  cur_word;
  int unsigned sent_idx;
  int unsigned busy_end;
  int unsigned swap_end;
  int unsigned bad_count;
  bit          in_fire;
  int unsigned hold_left;
  bit          held_once;

  // Loader state as tracked by the bench.
  phase_t      ld_phase;
  logic [7:0]  run_sum;
  logic [7:0]  held_low;
  logic [15:0] left_cnt;
  logic [15:0] wr_addr;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the parser by one word; return 1 when the word yields a result.
  function automatic bit parse_tape_word(input bit req, input logic [7:0] b,
                                         output result_t res);
    logic [15:0] word;
    word = {b, held_low};
    res = '0;
    if (ld_phase >= PH_DONE) return 1'b0;
    if (req) begin
      res.kind = (ld_phase == PH_HUNT || ld_phase == PH_SYNC2) ? KIND_OK : KIND_ERROR;
      ld_phase = PH_DONE;
      return 1'b1;
    end
    if (ld_phase != PH_HUNT) run_sum = run_sum + b;
    case (ld_phase)
      PH_HUNT: begin
        if (b == SYNC_FIRST) begin
          run_sum = 8'd1;
          ld_phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b == 8'd0) ld_phase = PH_CNT_LO;
        else ld_phase = PH_HUNT;
      end
      PH_CNT_LO: begin
        held_low = b;
        ld_phase = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        left_cnt = word;
        ld_phase = PH_ADR_LO;
      end
      PH_ADR_LO: begin
        held_low = b;
        ld_phase = PH_ADR_HI;
      end
      PH_ADR_HI: begin
        if (word == END_ADDRESS) begin
          res.kind = KIND_OK;
          ld_phase = PH_DONE;
          return 1'b1;
        end
        if (left_cnt == 16'd0) begin
          ld_phase = PH_HUNT;
        end else begin
          wr_addr = word;
          left_cnt = left_cnt - HEADER_BYTES;
          if (left_cnt == 16'd0) ld_phase = PH_CKSUM;
          else ld_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        res.kind = KIND_WRITE;
        res.addr = wr_addr;
        res.value = b;
        wr_addr = wr_addr + 16'd1;
        left_cnt = left_cnt - 16'd1;
        if (left_cnt == 16'd0) ld_phase = PH_CKSUM;
        return 1'b1;
      end
      PH_CKSUM: begin
        if (run_sum != 8'd0) begin
          res.kind = KIND_ERROR;
          ld_phase = PH_DONE;
          return 1'b1;
        end
        ld_phase = PH_HUNT;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int unsigned idle_pct(input bit rx, input int unsigned idx);
    if (idx < busy_end) return rx ? 74 : 38;
    if (idx < swap_end) return rx ? 38 : 74;
    return 0;
  endfunction

  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    if ($urandom_range(9) == 0) return 16'hFFF0 + 16'($urandom_range(15));
    do a = 16'($urandom); while (a == END_ADDRESS);
    return a;
  endfunction

  task automatic add_word(input bit req, input logic [7:0] b);
    tape_word_t w;
    w = '0;
    w.req = req;
    w.tbyte = b;
    tape_words.push_back(w);
  endtask

  task automatic pin_last(input kind_t kind, input logic [15:0] addr, input logic [7:0] val);
    tape_words[tape_words.size() - 1].pinned = 1'b1;
    tape_words[tape_words.size() - 1].pin = {kind, addr, val};
  endtask

  // Emit a block with random data; a nonzero skew corrupts the checksum.
  task automatic add_block(input logic [15:0] count, input logic [15:0] addr,
                           input logic [7:0] skew);
    logic [7:0]  sum;
    logic [7:0]  d;
    logic [15:0] n;
    int          i;
    sum = SYNC_FIRST + count[7:0] + count[15:8] + addr[7:0] + addr[15:8];
    add_word(1'b0, SYNC_FIRST);
    add_word(1'b0, 8'h00);
    add_word(1'b0, count[7:0]);
    add_word(1'b0, count[15:8]);
    add_word(1'b0, addr[7:0]);
    add_word(1'b0, addr[15:8]);
    if (count == 16'd0 || addr == END_ADDRESS) return;
    n = count - HEADER_BYTES;
    for (i = 0; i < n; i++) begin
      d = 8'($urandom);
      sum = sum + d;
      add_word(1'b0, d);
    end
    add_word(1'b0, 8'(8'd0 - sum) + skew);
  endtask

  task automatic note_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Sender: hold each word until taken, idle at random per phase.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.tape_byte = 8'h00;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!in_ch.valid || in_fire) begin
        if (sent_idx < tape_words.size() && $urandom_range(99) >= idle_pct(1'b0, sent_idx)) begin
          cur_word = tape_words[sent_idx];
          sent_idx++;
          in_ch.valid <= 1'b1;
          in_ch.req_type <= cur_word.req;
          in_ch.tape_byte <= cur_word.tbyte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held_once && rst_n && sent_idx >= swap_end + 30) begin
        held_once = 1'b1;
        hold_left = 400;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1, sent_idx));
      end
    end
  end

  // Check results against the oldest expectation, then predict the word taken.
  always @(posedge clk) begin : watch
    result_t r;
    result_t want;
    bit      has;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        note_bad($sformatf("unexpected result kind=%0d addr=%h value=%h",
                           out_ch.result_kind, out_ch.byte_address, out_ch.byte_value));
      end else begin
        want = due_results.pop_front();
        if (out_ch.result_kind !== want.kind || out_ch.byte_address !== want.addr ||
            out_ch.byte_value !== want.value)
          note_bad($sformatf("expected kind=%0d addr=%h value=%h, got kind=%0d addr=%h value=%h",
                             want.kind, want.addr, want.value, out_ch.result_kind,
                             out_ch.byte_address, out_ch.byte_value));
      end
    end
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      has = parse_tape_word(cur_word.req, cur_word.tbyte, r);
      if (cur_word.pinned) due_results.push_back(cur_word.pin);
      else if (has) due_results.push_back(r);
    end
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : main
    int          dir_n;
    int unsigned start;
    int unsigned k;
    int          i;
    rst_n = 1'b0;
    ld_phase = PH_HUNT;
    run_sum = 8'd0;
    held_low = 8'd0;
    left_cnt = 16'd0;
    wr_addr = 16'd0;

    foreach (tape_rows[j]) begin
      add_word(tape_rows[j].req, tape_rows[j].tbyte);
      if (tape_rows[j].pinned) pin_last(KIND_WRITE, tape_rows[j].paddr, tape_rows[j].pval);
    end
    dir_n = tape_words.size();

    // Mostly well-formed blocks; the rest is leader noise, bad syncs and empty blocks.
    while (tape_words.size() < dir_n + 1250) begin
      k = $urandom_range(99);
      if (k < 70) begin
        add_block(16'(HEADER_BYTES + $urandom_range(12)), pick_addr(), 8'd0);
      end else if (k < 80) begin
        add_block(16'd0, pick_addr(), 8'd0);
      end else if (k < 90) begin
        add_word(1'b0, SYNC_FIRST);
        add_word(1'b0, 8'($urandom_range(1, 255)));
      end else begin
        for (i = 0; i < $urandom_range(1, 4); i++) add_word(1'b0, 8'($urandom_range(2, 255)));
      end
    end
    busy_end = tape_words.size() / 3;
    swap_end = 2 * tape_words.size() / 3;

    // Exactly one way to end the load, since reset is never asserted again.
    case ($urandom_range(5))
      0: begin
        for (i = 0; i < $urandom_range(0, 3); i++) add_word(1'b0, 8'($urandom_range(2, 255)));
        add_word(1'b1, 8'($urandom));
        pin_last(KIND_OK, 16'd0, 8'd0);
      end
      1: begin
        add_word(1'b0, SYNC_FIRST);
        add_word(1'b1, 8'($urandom));
        pin_last(KIND_OK, 16'd0, 8'd0);
      end
      2: begin
        start = tape_words.size();
        add_block(16'(HEADER_BYTES + $urandom_range(6)), pick_addr(), 8'd0);
        k = $urandom_range(2, tape_words.size() - start - 1);
        while (tape_words.size() > start + k) void'(tape_words.pop_back());
        add_word(1'b1, 8'($urandom));
        pin_last(KIND_ERROR, 16'd0, 8'd0);
      end
      3: begin
        add_block(16'(HEADER_BYTES + $urandom_range(6)), pick_addr(),
                  8'($urandom_range(1, 255)));
        pin_last(KIND_ERROR, 16'd0, 8'd0);
      end
      4: begin
        // A count below the header size wraps to tens of thousands of data
        // bytes; cut the tape short after a few writes.
        start = tape_words.size();
        add_block(16'($urandom_range(1, 5)), pick_addr(), 8'd0);
        k = 6 + $urandom_range(1, 40);
        while (tape_words.size() > start + k) void'(tape_words.pop_back());
        add_word(1'b1, 8'($urandom));
        pin_last(KIND_ERROR, 16'd0, 8'd0);
      end
      default: begin
        add_block(16'($urandom), END_ADDRESS, 8'd0);
        pin_last(KIND_OK, 16'd0, 8'd0);
      end
    endcase

    // Words after the end must be taken and dropped.
    add_word(1'b1, 8'($urandom));
    for (i = 0; i < $urandom_range(3, 7); i++) add_word(1'($urandom_range(1)), 8'($urandom));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (!(sent_idx == tape_words.size() && !in_ch.valid));
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bad_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
